@@ src/dq_pkg.sv @@
package dq_pkg;

   localparam int DEPTH = 128;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int OCC_W = 8;

   localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
   localparam logic [1:0] REQ_POP_BACK   = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
   } dq_cmd_type;

   typedef struct packed {
      logic out_free;
   } dq_stat_type;

endpackage

@@ src/double_ended_queue.sv @@
// Double-ended queue of signed 32-bit words with DEPTH (128) entries held in a
// circular buffer memory. Each request transaction carries req_type in tuser
// (push front, push back, pop front, pop back) and the push word in tdata;
// each yields exactly one response with the popped word and occupancy in
// tdata and the status (done, full, empty) in tuser. A refused request leaves
// the queue unchanged and returns zero. A request first moves a pointer and
// accesses the memory, then loads the response register, and no new request
// is taken until that load is made. While the response register holds a
// response not yet taken, the load waits and req_tready stays low until it
// is made. No clearing pass follows reset.
module double_ended_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // push_value[31:0]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pop_value[31:0], occupancy[39:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import dq_pkg::*;

   dq_cmd_type  cmd;
   dq_stat_type stat;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ src/dq_ctrl.sv @@
module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  dq_pkg::dq_stat_type stat,
   output dq_pkg::dq_cmd_type  cmd
);
   import dq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/dq_datapath.sv @@
module dq_datapath (
   input  logic                clock,
   input  logic                reset,
   input  dq_pkg::dq_cmd_type  cmd,
   output dq_pkg::dq_stat_type stat,
   input  logic [31:0]         req_tdata,  // push_value[31:0]
   input  logic [1:0]          req_tuser,  // req_type[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,  // pop_value[31:0], occupancy[39:32]
   output logic [1:0]          rsp_tuser   // status[1:0]
);
   import dq_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [WORD_W-1:0] rd_ff;
   logic [1:0]        status_ff, status_in;
   logic              pop_ok_ff, pop_ok_in;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_value_ff;
   logic [1:0]        rsp_status_ff;
   logic [OCC_W-1:0]  rsp_occ_ff;

   logic              full, empty, wr_en;
   logic [PTR_W-1:0]  wr_addr, rd_addr;
   logic [PTR_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;

   always_comb begin
      full = (count_ff == CNT_W'(DEPTH));
      empty = (count_ff == '0);
      head_inc = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      head_dec = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - 1'b1;
      tail_inc = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      tail_dec = (tail_ff == '0) ? PTR_W'(DEPTH - 1) : tail_ff - 1'b1;

      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      status_in = ST_DONE;
      pop_ok_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = head_ff;
      rd_addr = head_ff;
      case (req_tuser)
         REQ_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               head_in = head_dec;
               wr_en = 1'b1;
               wr_addr = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         REQ_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               tail_in = tail_inc;
               wr_en = 1'b1;
               wr_addr = tail_ff;
               count_in = count_ff + 1'b1;
            end
         end
         REQ_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               head_in = head_inc;
               rd_addr = head_ff;
               pop_ok_in = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         REQ_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               tail_in = tail_dec;
               rd_addr = tail_dec;
               pop_ok_in = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         mem[wr_addr] <= req_tdata;
      end
      if (cmd.accept) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
      if (cmd.load) begin
         rsp_value_ff <= pop_ok_ff ? rd_ff : '0;
         rsp_status_ff <= status_ff;
         rsp_occ_ff <= OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("stored count above capacity");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && !req_tuser[1] && full |=> status_ff == ST_FULL && $stable(count_ff)
         && $stable(head_ff) && $stable(tail_ff))
      else $error("push to full queue changed state");

   a_empty_refused: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_tuser[1] && empty |=> status_ff == ST_EMPTY && !pop_ok_ff
         && $stable(count_ff))
      else $error("pop from empty queue changed state");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> stat.out_free)
      else $error("result register overwritten before transfer");

endmodule
